/* sv/uart_register_datagram_framer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the register datagram framer
// Checks clocked on i_clk, with or without the synchronous reset masking them.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_DATAGRAM_FRAMER_UNIT_MACROS_SVH
`define UART_REGISTER_DATAGRAM_FRAMER_UNIT_MACROS_SVH

// Checked outside reset only.
`define URDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define URDF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/urdf_pkg.sv */
// ----------------------------------------------------------------------------
// urdf_pkg
// Shared types, constants and the CRC-8 byte step for the datagram framer.
// ----------------------------------------------------------------------------
package urdf_pkg;

    // Echoed request bytes that precede the reply (0 to 4)
    localparam logic [3:0] ECHO_BYTES  = 4'd4;
    // Reply datagram: bytes 0..6 under CRC, byte 7 is the CRC
    localparam logic [3:0] REPLY_BYTES = 4'd7;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] REG_MASK   = 8'h7f;

    localparam logic [3:0] WRITE_LEN   = 4'd8;
    localparam logic [3:0] REQUEST_LEN = 4'd4;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RX    = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_TIMEOUT = 2'd1,
        STATUS_CRC     = 2'd2
    } t_status;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_ATTEMPTS = 2'd1;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  node_address;
        logic [6:0]  register_address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_item;

    // Up to eight results produced by one item
    typedef struct packed {
        logic            completion;  // read completion, else transmit bytes
        logic [3:0]      count;       // number of results, 0..8
        logic [7:0][7:0] bytes;       // bytes[0] goes out first
        logic [31:0]     data;
        t_status         status;
    } t_frame;

    // One byte through the CRC: data LSB first, register shifts MSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc;
        for (int b = 0; b < 8; b++) begin
            if (d[b]) begin
                c = c ^ 8'h80;
            end
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

/* sv/uart_register_datagram_framer_unit.sv */
// ----------------------------------------------------------------------------
// uart_register_datagram_framer_unit
// Frames register write and read accesses for a single-wire UART driver bus,
// collects the read reply, checks its CRC-8 and retries on failure.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   ----------------------------------------
//  input     i_valid  / o_ready           i_kind i_node_address i_register_address
//                                         i_write_data i_rx_byte
//  result    o_valid  / i_ready           o_out_kind o_tx_byte o_last_byte
//                                         o_read_data o_read_status
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index i_cfg_data
//
//  An accepted item is held in the input register; the engine then
//  turns it into a frame of 0 to 8 results in a single pass, and the emitter
//  hands these out one per cycle while i_ready is high. A write access yields
//  8 results, a sent request 4, a completion 1, and other items none.
//  The emitter's single frame buffer sets the rate: the next frame loads in
//  the cycle its predecessor's last result is taken.
//  Reset (synchronous, active low) clears the protocol state, the buffers and
//  sets timeout_ticks to 2000 and max_attempts to 2.
//  A stalled result side holds the frame; an item that yields results then
//  waits in the input register and o_ready drops until the frame drains.
// ----------------------------------------------------------------------------
module uart_register_datagram_framer_unit
    import urdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_node_address,
    input  logic [6:0]  i_register_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_read_status,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_item       r_item;
    logic [15:0] r_timeout_ticks;
    logic [1:0]  r_max_attempts;

    t_frame frame;
    logic   load_ready;
    logic   fire;
    logic   load;

    // An item with no results never waits on the emitter
    assign fire    = r_in_valid && ((frame.count == 4'd0) || load_ready);
    assign load    = fire && (frame.count != 4'd0);
    assign o_ready = !r_in_valid || fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.kind             <= t_kind'(i_kind);
            r_item.node_address     <= i_node_address;
            r_item.register_address <= i_register_address;
            r_item.write_data       <= i_write_data;
            r_item.rx_byte          <= i_rx_byte;
        end
    end

    // Config registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= 16'd2000;
            r_max_attempts  <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout_ticks <= i_cfg_data;
            end else if (i_cfg_index == CFG_ATTEMPTS) begin
                r_max_attempts <= i_cfg_data[1:0];
            end
        end
    end

    urdf_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (r_item),
        .i_fire          (fire),
        .i_timeout_ticks (r_timeout_ticks),
        .i_max_attempts  (r_max_attempts),
        .o_frame         (frame)
    );

    urdf_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_frame       (frame),
        .o_load_ready  (load_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_kind    (o_out_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte),
        .o_read_data   (o_read_data),
        .o_read_status (o_read_status)
    );

endmodule

/* sv/urdf_engine.sv */
// ----------------------------------------------------------------------------
// urdf_engine
// Protocol state and frame builder: turns one registered item into a frame.
// ----------------------------------------------------------------------------
module urdf_engine
    import urdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_fire,
    input  logic [15:0] i_timeout_ticks,
    input  logic [1:0]  i_max_attempts,
    output t_frame      o_frame
);

    `include "uart_register_datagram_framer_unit_macros.svh"

    logic        r_awaiting,    n_awaiting;
    logic [1:0]  r_pend_node,   n_pend_node;
    logic [6:0]  r_pend_reg,    n_pend_reg;
    logic [3:0]  r_reply_count, n_reply_count;
    logic [7:0]  r_reply_crc,   n_reply_crc;
    logic [31:0] r_reply_value, n_reply_value;
    logic [1:0]  r_attempts,    n_attempts;
    logic [15:0] r_wait_count,  n_wait_count;

    logic       end_attempt;
    t_status    end_status;
    logic       do_send;
    logic [3:0] reply_pos;
    logic [7:0] wr_crc;
    logic [7:0] rq_crc;
    logic [6:0][7:0] wr_bytes;

    assign reply_pos = r_reply_count - ECHO_BYTES;

    always_comb begin
        wr_bytes[0] = SYNC_BYTE;
        wr_bytes[1] = {6'd0, i_item.node_address};
        wr_bytes[2] = {1'b0, i_item.register_address} | WRITE_FLAG;
        wr_bytes[3] = i_item.write_data[31:24];
        wr_bytes[4] = i_item.write_data[23:16];
        wr_bytes[5] = i_item.write_data[15:8];
        wr_bytes[6] = i_item.write_data[7:0];
        wr_crc = 8'd0;
        for (int i = 0; i < 7; i++) begin
            wr_crc = crc_byte(wr_crc, wr_bytes[i]);
        end
    end

    always_comb begin
        n_awaiting    = r_awaiting;
        n_pend_node   = r_pend_node;
        n_pend_reg    = r_pend_reg;
        n_reply_count = r_reply_count;
        n_reply_crc   = r_reply_crc;
        n_reply_value = r_reply_value;
        n_attempts    = r_attempts;
        n_wait_count  = r_wait_count;
        end_attempt   = 1'b0;
        end_status    = STATUS_OK;
        do_send       = 1'b0;
        rq_crc        = 8'd0;
        o_frame       = '0;

        unique case (i_item.kind)
            KIND_WRITE: begin
                if (!r_awaiting) begin
                    o_frame.count = WRITE_LEN;
                    for (int i = 0; i < 7; i++) begin
                        o_frame.bytes[i] = wr_bytes[i];
                    end
                    o_frame.bytes[7] = wr_crc;
                end
            end
            KIND_READ: begin
                if (!r_awaiting) begin
                    n_pend_node = i_item.node_address;
                    n_pend_reg  = i_item.register_address;
                    n_attempts  = 2'd1;
                    do_send     = 1'b1;
                end
            end
            KIND_RX: begin
                if (r_awaiting) begin
                    n_reply_count = r_reply_count + 4'd1;
                    if (r_reply_count >= ECHO_BYTES) begin
                        if (reply_pos < REPLY_BYTES) begin
                            n_reply_crc = crc_byte(r_reply_crc, i_item.rx_byte);
                            if (reply_pos >= 4'd3) begin
                                n_reply_value = {r_reply_value[23:0], i_item.rx_byte};
                            end
                        end else begin
                            end_attempt = 1'b1;
                            end_status  = (i_item.rx_byte == r_reply_crc) ?
                                          STATUS_OK : STATUS_CRC;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (r_awaiting) begin
                    if (r_wait_count != 16'hffff) begin
                        n_wait_count = r_wait_count + 16'd1;
                    end
                    if (({1'b0, r_wait_count} + 17'd1) >= {1'b0, i_timeout_ticks}) begin
                        end_attempt = 1'b1;
                        end_status  = STATUS_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase

        // Failed attempt with budget left resends, otherwise complete
        if (end_attempt) begin
            if (end_status != STATUS_OK && r_attempts < i_max_attempts) begin
                n_attempts = r_attempts + 2'd1;
                do_send    = 1'b1;
            end else begin
                n_awaiting       = 1'b0;
                o_frame.completion = 1'b1;
                o_frame.count    = 4'd1;
                o_frame.data     = (end_status == STATUS_OK) ? r_reply_value : 32'd0;
                o_frame.status   = end_status;
                n_reply_count    = 4'd0;
                n_wait_count     = 16'd0;
            end
        end

        if (do_send) begin
            o_frame.count    = REQUEST_LEN;
            o_frame.bytes[0] = SYNC_BYTE;
            o_frame.bytes[1] = {6'd0, n_pend_node};
            o_frame.bytes[2] = {1'b0, n_pend_reg} & REG_MASK;
            rq_crc = crc_byte(8'd0, SYNC_BYTE);
            rq_crc = crc_byte(rq_crc, o_frame.bytes[1]);
            rq_crc = crc_byte(rq_crc, o_frame.bytes[2]);
            o_frame.bytes[3] = rq_crc;
            n_awaiting    = 1'b1;
            n_reply_count = 4'd0;
            n_reply_crc   = 8'd0;
            n_reply_value = 32'd0;
            n_wait_count  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting    <= 1'b0;
            r_pend_node   <= 2'd0;
            r_pend_reg    <= 7'd0;
            r_reply_count <= 4'd0;
            r_reply_crc   <= 8'd0;
            r_reply_value <= 32'd0;
            r_attempts    <= 2'd0;
            r_wait_count  <= 16'd0;
        end else if (i_fire) begin
            r_awaiting    <= n_awaiting;
            r_pend_node   <= n_pend_node;
            r_pend_reg    <= n_pend_reg;
            r_reply_count <= n_reply_count;
            r_reply_crc   <= n_reply_crc;
            r_reply_value <= n_reply_value;
            r_attempts    <= n_attempts;
            r_wait_count  <= n_wait_count;
        end
    end

    `URDF_ASSERT(a_await_has_attempt, r_awaiting |-> r_attempts != 2'd0, "awaiting with no attempt")
    `URDF_ASSERT(a_count_bounded, r_reply_count <= (ECHO_BYTES + REPLY_BYTES), "reply count overrun")
    `URDF_ASSERT_ALWAYS(a_idle_count_clear, !r_awaiting |-> r_reply_count == 4'd0, "count set while idle")

endmodule

/* sv/urdf_emitter.sv */
// ----------------------------------------------------------------------------
// urdf_emitter
// Result buffer: holds one frame and hands its results out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module urdf_emitter
    import urdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_frame      i_frame,
    output logic        o_load_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_read_status
);

    `include "uart_register_datagram_framer_unit_macros.svh"

    logic            r_completion;
    logic [3:0]      r_cnt;
    logic [2:0]      r_idx;
    logic [7:0][7:0] r_bytes;
    logic [31:0]     r_data;
    t_status         r_status;

    logic at_last;
    logic take;

    assign at_last = ({1'b0, r_idx} == (r_cnt - 4'd1));
    assign take    = o_valid && i_ready;

    assign o_valid       = (r_cnt != 4'd0);
    assign o_load_ready  = !o_valid || (take && at_last);
    assign o_out_kind    = r_completion;
    assign o_tx_byte     = r_completion ? 8'd0 : r_bytes[r_idx];
    assign o_last_byte   = !r_completion && at_last;
    assign o_read_data   = r_completion ? r_data : 32'd0;
    assign o_read_status = r_completion ? r_status : STATUS_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
            r_idx <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_frame.count;
            r_idx <= 3'd0;
        end else if (take) begin
            if (at_last) begin
                r_cnt <= 4'd0;
                r_idx <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_completion <= i_frame.completion;
            r_bytes      <= i_frame.bytes;
            r_data       <= i_frame.data;
            r_status     <= i_frame.status;
        end
    end

    `URDF_ASSERT(a_idx_in_range, o_valid |-> {1'b0, r_idx} < r_cnt, "index past frame")
    `URDF_ASSERT(a_load_when_free, i_load |-> o_load_ready, "frame overwritten")
    `URDF_ASSERT(a_completion_single, (o_valid && r_completion) |-> r_cnt == 4'd1, "completion frame too long")

endmodule
